// File: hw/rtl/pteq_pkg.sv
// Package for the per-task event queue dispatch unit.
// Holds the operation and status codes and the response record; depends on nothing.
package pteq_pkg;

	// Width of one queued event and of the dispatch ready mask.
	localparam int EVENT_W = 8;
	localparam int MASK_W  = 8;

	// Operation codes carried by the input beat.
	typedef enum logic [1:0] {
		OP_CREATE   = 2'd0,
		OP_SEND     = 2'd1,
		OP_READ     = 2'd2,
		OP_DISPATCH = 2'd3
	} op_t;

	// Status codes carried by the result beat.
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_EXISTS  = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	// Decision made for one item while the event memory read is in flight.
	typedef struct packed {
		status_t             status;
		logic                rd_hit;
		logic [MASK_W-1:0]   mask;
	} resp_t;

endpackage

// File: hw/rtl/pteq_event_mem.sv
// Event storage for all task queues: one write or one read port, read data registered.
// Uses pteq_pkg for the event width.
module pteq_event_mem
	import pteq_pkg::*;
#(
	parameter int DEPTH  = 40,
	parameter int ADDR_W = 6
) (
	input  logic               clk,
	input  logic               we,
	input  logic               re,
	input  logic [ADDR_W-1:0]  addr,
	input  logic [EVENT_W-1:0] wdata,
	output logic [EVENT_W-1:0] rdata
);

	logic [EVENT_W-1:0] mem [DEPTH];
	logic [EVENT_W-1:0] rdata_q;

	// Synchronous write, registered read; entries have no reset.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/pteq_queue_ctrl.sv
// Queue pointer table and operation decoder: head, tail and created flag per task.
// Uses pteq_pkg for codes and the response record; drives the event memory port.
module pteq_queue_ctrl
	import pteq_pkg::*;
#(
	parameter int NUM_TASKS   = 8,
	parameter int QUEUE_DEPTH = 5,
	parameter int ADDR_W      = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic [1:0]         operation,
	input  logic [3:0]         task_id,
	input  logic [EVENT_W-1:0] event_value,
	output resp_t              resp,
	output logic               mem_we,
	output logic               mem_re,
	output logic [ADDR_W-1:0]  mem_addr,
	output logic [EVENT_W-1:0] mem_wdata
);

	localparam int IDX_W  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int SCAN_N = (NUM_TASKS < MASK_W) ? NUM_TASKS : MASK_W;

	logic [PTR_W-1:0] head_q [NUM_TASKS];
	logic [PTR_W-1:0] tail_q [NUM_TASKS];
	logic             created_q [NUM_TASKS];

	logic [IDX_W-1:0] idx;
	logic             task_ok;
	logic [PTR_W-1:0] cur_head;
	logic [PTR_W-1:0] cur_tail;
	logic             cur_created;
	logic [PTR_W-1:0] slot;
	logic             head_adv;
	logic             tail_adv;
	logic             set_created;

	// Wrap a queue pointer at the queue depth.
	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + PTR_W'(1);
		end
		return n;
	endfunction

	// Look up the addressed task; only valid ids ever index the tables.
	assign idx         = task_id[IDX_W-1:0];
	assign task_ok     = {1'b0, task_id} < 5'(NUM_TASKS);
	assign cur_head    = task_ok ? head_q[idx] : '0;
	assign cur_tail    = task_ok ? tail_q[idx] : '0;
	assign cur_created = task_ok ? created_q[idx] : 1'b0;

	// Decode the operation into a response and a memory access.
	always_comb begin
		resp        = '{status: ST_OK, rd_hit: 1'b0, mask: '0};
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		mem_wdata   = event_value;
		slot        = cur_head;
		head_adv    = 1'b0;
		tail_adv    = 1'b0;
		set_created = 1'b0;
		case (op_t'(operation))
			OP_DISPATCH: begin
				for (int i = 0; i < SCAN_N; i++) begin
					resp.mask[i] = created_q[i] && (head_q[i] != tail_q[i]);
				end
			end
			OP_CREATE: begin
				if (!task_ok) begin
					resp.status = ST_INVALID;
				end else if (cur_created) begin
					resp.status = ST_EXISTS;
				end else begin
					mem_we      = 1'b1;
					mem_wdata   = '0;
					head_adv    = 1'b1;
					set_created = 1'b1;
				end
			end
			OP_SEND: begin
				if (!task_ok) begin
					resp.status = ST_INVALID;
				end else begin
					mem_we   = 1'b1;
					head_adv = 1'b1;
				end
			end
			OP_READ: begin
				slot = cur_tail;
				if (!task_ok) begin
					resp.status = ST_INVALID;
				end else if (cur_head == cur_tail) begin
					resp.status = ST_EMPTY;
				end else begin
					mem_re      = 1'b1;
					resp.rd_hit = 1'b1;
					tail_adv    = 1'b1;
				end
			end
			default: begin
				resp.status = ST_OK;
			end
		endcase
	end

	// Flat memory address: task base plus slot within the queue.
	assign mem_addr = ADDR_W'(idx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot);

	// Pointer and created-flag updates, applied when the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TASKS; i++) begin
				head_q[i]    <= '0;
				tail_q[i]    <= '0;
				created_q[i] <= 1'b0;
			end
		end else if (req_valid && task_ok) begin
			if (head_adv) begin
				head_q[idx] <= next_ptr(cur_head);
			end
			if (tail_adv) begin
				tail_q[idx] <= next_ptr(cur_tail);
			end
			if (set_created) begin
				created_q[idx] <= 1'b1;
			end
		end
	end

`ifndef SYNTH
	// The memory port never writes and reads in the same cycle.
	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("event memory written and read together");

	// A task's pointers stay inside its queue.
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		task_ok |-> (cur_head < PTR_W'(QUEUE_DEPTH - 1) || cur_head == PTR_W'(QUEUE_DEPTH - 1))
			&& (cur_tail < PTR_W'(QUEUE_DEPTH - 1) || cur_tail == PTR_W'(QUEUE_DEPTH - 1)))
		else $error("queue pointer outside queue depth");

	// A successful read only happens on a non-empty queue and always moves the tail.
	a_read_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && resp.rd_hit) |=> tail_q[$past(idx)] != $past(cur_tail))
		else $error("read did not advance the tail");
`endif

endmodule

// File: hw/rtl/per_task_event_queue_dispatch_unit.sv
// Per-task event queue dispatch unit: create, send, read and dispatch over per-task queues.
// Path: an accepted input beat passes through stage one (decision held with the event memory
// read) and then the output register before its result beat is presented.
// Throughput: one item per cycle unless out_stall holds the output; then in_stall can rise.
// Reset: arst_n clears all pointers, created flags and valids; the event memory is not cleared.
// Uses pteq_pkg, pteq_queue_ctrl and pteq_event_mem.
module per_task_event_queue_dispatch_unit
	import pteq_pkg::*;
#(
	parameter int NUM_TASKS   = 8,
	parameter int QUEUE_DEPTH = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic [3:0]         task_id,
	input  logic [EVENT_W-1:0] event_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [EVENT_W-1:0] read_value,
	output logic [MASK_W-1:0]  ready_mask
);

	localparam int MEM_DEPTH = NUM_TASKS * QUEUE_DEPTH;
	localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	logic               accept;
	logic               out_free;
	resp_t              resp;
	logic               mem_we;
	logic               mem_re;
	logic [ADDR_W-1:0]  mem_addr;
	logic [EVENT_W-1:0] mem_wdata;
	logic [EVENT_W-1:0] mem_rdata;

	logic               valid_s1;
	resp_t              resp_s1;
	logic               out_valid_q;
	status_t            status_q;
	logic [EVENT_W-1:0] read_value_q;
	logic [MASK_W-1:0]  ready_mask_q;

	// Handshake: the output register frees when empty or taken this cycle.
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	pteq_queue_ctrl #(
		.NUM_TASKS   (NUM_TASKS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ADDR_W      (ADDR_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (accept),
		.operation   (operation),
		.task_id     (task_id),
		.event_value (event_value),
		.resp        (resp),
		.mem_we      (mem_we),
		.mem_re      (mem_re),
		.mem_addr    (mem_addr),
		.mem_wdata   (mem_wdata)
	);

	pteq_event_mem #(
		.DEPTH  (MEM_DEPTH),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we && accept),
		.re    (mem_re && accept),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// Stage one holds the decision while the memory read completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			resp_s1 <= resp;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	// Output register payload, merging the read data for a successful read.
	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			status_q     <= resp_s1.status;
			read_value_q <= resp_s1.rd_hit ? mem_rdata : '0;
			ready_mask_q <= resp_s1.mask;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign read_value = read_value_q;
	assign ready_mask = ready_mask_q;

endmodule
